FILE: sv/unit_vector_angle_defines.svh
// ----------------------------------------------------------------------------
// unit_vector_angle assertion macros
// shared property shapes for the unit vector angle checks
// ----------------------------------------------------------------------------
`ifndef UNIT_VECTOR_ANGLE_DEFINES_SVH
`define UNIT_VECTOR_ANGLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define UVA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UVA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/uva_pkg.sv
// ----------------------------------------------------------------------------
// uva_pkg
// shared constants, types and helpers of the unit vector angle pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uva_pkg;

	// component width on the input bus
	localparam int CW      = 16;
	localparam int TDATA_W = ((6 * CW + 7) / 8) * 8;

	// fixed-point constants
	localparam logic [31:0] ONE_Q30     = 32'd1 << 30;
	localparam logic [63:0] ONE_Q60     = 64'd1 << 60;
	localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
	localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
	localparam int CORDIC_STEPS = 20;
	localparam int SQRT_STEPS   = 32;
	localparam logic [14:0] THR_RESET = 15'd31130;
	localparam logic [15:0] ANGLE_MAX = 16'd51472;

	// branch codes
	localparam logic [1:0] BR_ACOS = 2'd0;
	localparam logic [1:0] BR_ASIN = 2'd1;
	localparam logic [1:0] BR_OPP  = 2'd2;

	// sideband carried alongside a square root
	typedef struct packed {
		logic [1:0]         branch;
		logic signed [31:0] val;
	} side_t;

	// bring a component to Q1.15: drop low bits or append zeros
	function automatic logic signed [15:0] to_q15(input logic [CW-1:0] raw);
		logic [CW+15:0] ext;
		ext = {raw, 16'b0};
		return ext[CW+15 -: 16];
	endfunction

	// arctangent step of a CORDIC iteration, Q.24
	function automatic logic signed [27:0] atan_step(input int i);
		logic signed [27:0] s;
		unique case (i)
			0: s = 28'sd13176795;
			1: s = 28'sd7778716;
			2: s = 28'sd4110060;
			3: s = 28'sd2086331;
			4: s = 28'sd1047214;
			5: s = 28'sd524117;
			6: s = 28'sd262123;
			7: s = 28'sd131069;
			default: s = 28'sd1 <<< (24 - i);
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: sv/uva_front.sv
// ----------------------------------------------------------------------------
// uva_front
// dot and cross products, branch choice and squared cross length
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uva_front
	import uva_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               in_valid,
	input  wire logic [TDATA_W-1:0] in_data,
	input  wire logic [14:0]        thr,
	output logic                    out_valid,
	output logic [63:0]             out_sum,
	output side_t                   out_side
);

	logic [4:0] valid_q;

	logic signed [15:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic signed [31:0] pxx_s2, pyy_s2, pzz_s2;
	logic signed [31:0] pyz_s2, pzy_s2, pzx_s2, pxz_s2, pxy_s2, pyx_s2;
	logic signed [33:0] dot_s3;
	logic signed [32:0] cx_s3, cy_s3, cz_s3;
	logic [1:0]         br_s3;
	logic [63:0]        sx_s4, sy_s4, sz_s4;
	side_t              side_s4;
	logic [63:0]        sum_s5;
	side_t              side_s5;

	logic signed [33:0] thr_w;
	logic signed [33:0] dot_w;
	logic signed [32:0] ax_abs, ay_abs, az_abs;
	logic signed [31:0] dclamp;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[3:0], in_valid};
		end
	end

	// stage 1: components to Q1.15
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= to_q15(in_data[0*CW +: CW]);
			ay_s1 <= to_q15(in_data[1*CW +: CW]);
			az_s1 <= to_q15(in_data[2*CW +: CW]);
			bx_s1 <= to_q15(in_data[3*CW +: CW]);
			by_s1 <= to_q15(in_data[4*CW +: CW]);
			bz_s1 <= to_q15(in_data[5*CW +: CW]);
		end
	end

	// stage 2: the nine products
	always_ff @(posedge clk) begin
		if (adv) begin
			pxx_s2 <= ax_s1 * bx_s1;
			pyy_s2 <= ay_s1 * by_s1;
			pzz_s2 <= az_s1 * bz_s1;
			pyz_s2 <= ay_s1 * bz_s1;
			pzy_s2 <= az_s1 * by_s1;
			pzx_s2 <= az_s1 * bx_s1;
			pxz_s2 <= ax_s1 * bz_s1;
			pxy_s2 <= ax_s1 * by_s1;
			pyx_s2 <= ay_s1 * bx_s1;
		end
	end

	// stage 3: dot, cross and branch choice
	assign thr_w = $signed({4'b0, thr, 15'b0});
	assign dot_w = 34'(pxx_s2) + 34'(pyy_s2) + 34'(pzz_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			dot_s3 <= dot_w;
			cx_s3  <= 33'(pyz_s2) - 33'(pzy_s2);
			cy_s3  <= 33'(pzx_s2) - 33'(pxz_s2);
			cz_s3  <= 33'(pxy_s2) - 33'(pyx_s2);
			priority if (dot_w > thr_w) begin
				br_s3 <= BR_ASIN;
			end else if (dot_w < -thr_w) begin
				br_s3 <= BR_OPP;
			end else begin
				br_s3 <= BR_ACOS;
			end
		end
	end

	// stage 4: squared cross components and clamped dot
	assign ax_abs = cx_s3[32] ? -cx_s3 : cx_s3;
	assign ay_abs = cy_s3[32] ? -cy_s3 : cy_s3;
	assign az_abs = cz_s3[32] ? -cz_s3 : cz_s3;

	always_comb begin
		priority if (dot_s3 > $signed({2'b0, ONE_Q30})) begin
			dclamp = $signed(ONE_Q30);
		end else if (dot_s3 < -$signed({2'b0, ONE_Q30})) begin
			dclamp = -$signed(ONE_Q30);
		end else begin
			dclamp = dot_s3[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s4          <= ax_abs[31:0] * ax_abs[31:0];
			sy_s4          <= ay_abs[31:0] * ay_abs[31:0];
			sz_s4          <= az_abs[31:0] * az_abs[31:0];
			side_s4.branch <= br_s3;
			side_s4.val    <= dclamp;
		end
	end

	// stage 5: squared cross length
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s5  <= sx_s4 + sy_s4 + sz_s4;
			side_s5 <= side_s4;
		end
	end

	assign out_valid = valid_q[4];
	assign out_sum   = sum_s5;
	assign out_side  = side_s5;

endmodule

`default_nettype wire

FILE: sv/uva_sqrt.sv
// ----------------------------------------------------------------------------
// uva_sqrt
// pipelined floor square root of a 64-bit value, one result bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uva_sqrt
	import uva_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        in_valid,
	input  wire logic [63:0] in_n,
	input  wire side_t       in_side,
	output logic             out_valid,
	output logic [31:0]      out_root,
	output side_t            out_side
);

	logic [SQRT_STEPS:1] valid_s;
	logic [63:0]         n_s    [1:SQRT_STEPS];
	logic [63:0]         r_s    [1:SQRT_STEPS];
	side_t               side_s [1:SQRT_STEPS];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (adv) begin
			valid_s <= {valid_s[SQRT_STEPS-1:1], in_valid};
		end
	end

	// one restoring step per stage
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] n_in;
		logic [63:0] r_in;
		side_t       side_in;
		logic [63:0] rb;
		logic        ge;

		// stage inputs: the request itself or the previous stage
		if (k == 0) begin : g_first
			assign n_in    = in_n;
			assign r_in    = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign n_in    = n_s[k];
			assign r_in    = r_s[k];
			assign side_in = side_s[k];
		end

		assign rb = r_in + BIT;
		assign ge = n_in >= rb;

		always_ff @(posedge clk) begin
			if (adv) begin
				n_s[k+1]    <= ge ? n_in - rb : n_in;
				r_s[k+1]    <= ge ? (r_in >> 1) + BIT : r_in >> 1;
				side_s[k+1] <= side_in;
			end
		end
	end

	assign out_valid = valid_s[SQRT_STEPS];
	assign out_root  = r_s[SQRT_STEPS][31:0];
	assign out_side  = side_s[SQRT_STEPS];

endmodule

`default_nettype wire

FILE: sv/uva_cordic.sv
// ----------------------------------------------------------------------------
// uva_cordic
// vectoring cordic atan2 with clamp and rounding to Q2.14
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uva_cordic
	import uva_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adv,
	input  wire logic        in_valid,
	input  wire logic [31:0] in_leg,
	input  wire side_t       in_side,
	output logic             out_valid,
	output logic [15:0]      out_angle,
	output logic [1:0]       out_branch
);

	logic [CORDIC_STEPS+1:0] valid_q;
	logic signed [33:0]      x_s  [0:CORDIC_STEPS];
	logic signed [33:0]      y_s  [0:CORDIC_STEPS];
	logic signed [27:0]      z_s  [0:CORDIC_STEPS];
	logic [1:0]              br_s [0:CORDIC_STEPS];
	logic [15:0]             angle_s21;
	logic [1:0]              branch_s21;

	logic signed [33:0] leg_w, val_w, x0, y0;
	logic signed [27:0] zc;
	logic [27:0]        zr;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[CORDIC_STEPS:0], in_valid};
		end
	end

	// operands per branch
	assign leg_w = $signed({2'b0, in_leg});
	assign val_w = 34'(in_side.val);

	always_comb begin
		unique case (in_side.branch)
			BR_ASIN: begin
				x0 = leg_w;
				y0 = val_w;
			end
			BR_OPP: begin
				x0 = -leg_w;
				y0 = val_w;
			end
			default: begin
				x0 = val_w;
				y0 = leg_w;
			end
		endcase
	end

	// pre-rotation into the right half plane
	always_ff @(posedge clk) begin
		if (adv) begin
			br_s[0] <= in_side.branch;
			if (x0 < 0) begin
				x_s[0] <= y0;
				y_s[0] <= -x0;
				z_s[0] <= HALF_PI_Q24;
			end else begin
				x_s[0] <= x0;
				y_s[0] <= y0;
				z_s[0] <= '0;
			end
		end
	end

	// micro-rotations
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
		localparam logic signed [27:0] STEP = atan_step(i);
		logic signed [33:0] dx, dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (adv) begin
				br_s[i+1] <= br_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + STEP;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - STEP;
				end
			end
		end
	end

	// clamp to 0..pi and round to Q2.14
	always_comb begin
		priority if (z_s[CORDIC_STEPS] < 0) begin
			zc = '0;
		end else if (z_s[CORDIC_STEPS] > PI_Q24) begin
			zc = PI_Q24;
		end else begin
			zc = z_s[CORDIC_STEPS];
		end
	end
	assign zr = zc + 28'd512;

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s21  <= zr[25:10];
			branch_s21 <= br_s[CORDIC_STEPS];
		end
	end

	assign out_valid  = valid_q[CORDIC_STEPS+1];
	assign out_angle  = angle_s21;
	assign out_branch = branch_s21;

endmodule

`default_nettype wire

FILE: sv/unit_vector_angle.sv
// Angle between two unit 3-vectors, radians in unsigned Q2.14.
// Input stream s_*: s_tdata carries a_x, a_y, a_z, b_x, b_y, b_z, signed
// Q1.15, a_x in the lowest bits. Output stream m_*: m_tdata is the angle,
// m_tuser the branch (acos of dot, asin near parallel, pi minus asin near
// opposite). cfg_* writes the 15-bit near threshold at any handshake.
// One request is taken per cycle while the output queue has room. The
// depth comes mostly from two 32-stage square roots, one bit each, and
// a 20-step cordic, one rotation per stage.
// Results enter a two-entry output queue; the pipeline freezes only while
// the queue is full, so a stalled receiver drops s_tready as soon as a
// second result waits, and nothing is lost or repeated.
// Reset clears all valid bits and the queue and sets the threshold to
// 31130 (about 0.95).
// ----------------------------------------------------------------------------
// unit_vector_angle
// top level: front products, two square roots, cordic and output queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "unit_vector_angle_defines.svh"

module unit_vector_angle
	import uva_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [TDATA_W-1:0] s_tdata,  // a_x, a_y, a_z, b_x, b_y, b_z
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [15:0]             m_tdata,  // angle
	output logic [1:0]              m_tuser,  // branch
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [14:0]        cfg_data  // near_threshold
);

	logic [14:0] thr_q;
	logic        adv;

	logic        f_valid;
	logic [63:0] f_sum;
	side_t       f_side;

	logic        q1_valid;
	logic [31:0] q1_root;
	side_t       q1_side;

	logic [2:0]         mv_q;
	side_t              side_s1, side_s2, side_s3;
	logic [30:0]        mag_w;
	logic [61:0]        sq_s2;
	logic [63:0]        arg_s3;
	logic signed [31:0] v_w;

	logic        q2_valid;
	logic [31:0] q2_root;
	side_t       q2_side;

	logic        res_valid;
	logic [15:0] res_angle;
	logic [1:0]  res_branch;

	logic [1:0]  cnt_q;
	logic [17:0] ent0_q, ent1_q;
	logic        push, pop;

	// threshold register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// pipeline advances while the queue has room
	assign adv      = cnt_q != 2'd2;
	assign s_tready = adv;

	uva_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.in_data   (s_tdata),
		.thr       (thr_q),
		.out_valid (f_valid),
		.out_sum   (f_sum),
		.out_side  (f_side)
	);

	// cross length
	uva_sqrt u_len (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (f_valid),
		.in_n      (f_sum),
		.in_side   (f_side),
		.out_valid (q1_valid),
		.out_root  (q1_root),
		.out_side  (q1_side)
	);

	// pick the asin or acos argument
	always_comb begin
		priority if (q1_side.branch == BR_ACOS) begin
			v_w = q1_side.val;
		end else if (q1_root > ONE_Q30) begin
			v_w = $signed(ONE_Q30);
		end else begin
			v_w = $signed(q1_root);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= '0;
		end else if (adv) begin
			mv_q <= {mv_q[1:0], q1_valid};
		end
	end

	assign mag_w = side_s1.val[31] ? 31'(-side_s1.val) : side_s1.val[30:0];

	// square, then 1 - v^2
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.branch <= q1_side.branch;
			side_s1.val    <= v_w;
			sq_s2          <= mag_w * mag_w;
			side_s2        <= side_s1;
			arg_s3         <= ONE_Q60 - 64'(sq_s2);
			side_s3        <= side_s2;
		end
	end

	// complementary leg
	uva_sqrt u_leg (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (mv_q[2]),
		.in_n      (arg_s3),
		.in_side   (side_s3),
		.out_valid (q2_valid),
		.out_root  (q2_root),
		.out_side  (q2_side)
	);

	uva_cordic u_cordic (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (q2_valid),
		.in_leg     (q2_root),
		.in_side    (q2_side),
		.out_valid  (res_valid),
		.out_angle  (res_angle),
		.out_branch (res_branch)
	);

	// two-entry output queue
	assign push = adv && res_valid;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					ent0_q <= {res_branch, res_angle};
				end else begin
					ent1_q <= {res_branch, res_angle};
				end
			end
			2'b01: begin
				ent0_q <= ent1_q;
			end
			2'b11: begin
				ent0_q <= {res_branch, res_angle};
			end
			default: begin
				ent0_q <= ent0_q;
			end
		endcase
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = ent0_q[15:0];
	assign m_tuser  = ent0_q[17:16];

	// checks
	`UVA_ASSERT_NOW(a_cnt_legal, 1'b1, cnt_q != 2'd3, "output queue count out of range")
	`UVA_ASSERT_NOW(a_angle_range, m_tvalid, m_tdata <= ANGLE_MAX, "angle beyond pi")
	`UVA_ASSERT_NOW(a_branch_legal, m_tvalid, m_tuser != 2'd3, "undefined branch code")
	`UVA_ASSERT_NEXT(a_tail_hold, !adv && res_valid, res_valid, "result dropped while frozen")

endmodule

`default_nettype wire
